### hdl/rsgc_pkg.sv
// ----------------------------------------------------------------------------
// rsgc_pkg
// Types and constants shared by the RS steganalysis group counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsgc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_COUNT  = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_SELECT = 2'd1;
  localparam logic [1:0] CFG_MASK_PATTERN   = 2'd2;

  // Configuration reset values
  localparam logic [2:0] CHANNEL_COUNT_RST  = 3'd3;
  localparam logic [1:0] CHANNEL_SELECT_RST = 2'd0;
  localparam logic [7:0] MASK_PATTERN_RST   = 8'd20;

  // Legal channel count range
  localparam logic [2:0] CHANNEL_COUNT_MIN = 3'd1;
  localparam logic [2:0] CHANNEL_COUNT_MAX = 3'd4;

  // Mask entry codes
  localparam logic [1:0] MASK_NONE  = 2'd0;
  localparam logic [1:0] MASK_PLUS  = 2'd1;
  localparam logic [1:0] MASK_MINUS = 2'd2;

  localparam logic [7:0] PIX_MAX = 8'd255;
  localparam int unsigned SUM_W     = 11;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned OUT_CNT_W = 24;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned OUT_W     = 6 * OUT_CNT_W + RATE_W;

  // Class counter slots
  localparam logic [2:0] CNT_REGULAR  = 3'd0;
  localparam logic [2:0] CNT_SINGULAR = 3'd1;
  localparam logic [2:0] CNT_UNUSABLE = 3'd2;
  localparam logic [2:0] CNT_INV_OFS  = 3'd3;
  localparam logic [2:0] CNT_REG_INV  = 3'd3;
  localparam logic [2:0] CNT_SING_INV = 3'd4;
  localparam logic [2:0] CNT_UNUS_INV = 3'd5;

  // Sequencer step numbers
  localparam logic [2:0] DIFF_LAST   = 3'd5;
  localparam logic [2:0] CLASS_LAST  = 3'd1;
  localparam logic [2:0] RS_NUM      = 3'd0;
  localparam logic [2:0] RS_PAIR     = 3'd1;
  localparam logic [2:0] RS_DEN      = 3'd2;
  localparam logic [2:0] RS_ABS_NUM  = 3'd3;
  localparam logic [2:0] RS_ABS_DEN  = 3'd4;

  // Rate saturation bounds
  localparam logic [RATE_W-1:0] RATE_MAX = 32'h7fff_ffff;
  localparam logic [RATE_W-1:0] RATE_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CLASS,
    ST_RATE,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_ADDABS
  } alu_op_e;

  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

endpackage

`default_nettype wire

### hdl/rs_steganalysis_group_counter_top.sv
// ----------------------------------------------------------------------------
// rs_steganalysis_group_counter_top
// RS group classification over one channel of a byte stream, with the
// embedding estimate computed by a serial divider on the last byte.
// ----------------------------------------------------------------------------
// Sequencing: an unselected byte or the first byte of a group is taken in ST_IDLE only,
//   any other selected byte runs six shared-ALU steps and then the class steps if it closes a group.
// A byte marked last adds 5 ALU steps, then the serial divide, then the load of the result
//   register, which waits while the previous result is unread; with
//   R+R'-S-S' = 0 it takes only 3 ALU steps and no divider.
// Reset: async active low; registers take their defaults, stream state and counts clear.
`timescale 1ns / 1ps
`default_nettype none

module rs_steganalysis_group_counter_top
  import rsgc_pkg::*;
#(
  parameter int unsigned GROUP_LEN  = 4,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  // sample stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] sample
  input  logic             s_axis_tlast,   // last
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [23:0] regular, [47:24] singular, [71:48] unusable, [95:72] regular_inv,
  // [119:96] singular_inv, [143:120] unusable_inv, [175:144] rate_q16
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned POS_W  = (GROUP_LEN > 2) ? $clog2(GROUP_LEN) : 1;
  localparam int unsigned ALU_W  = (COUNT_BITS + 2 > SUM_W + 1) ? COUNT_BITS + 2 : SUM_W + 1;
  localparam int unsigned QUOT_W = COUNT_BITS + FRAC_BITS + 2;
  localparam int unsigned SAT_W  = (QUOT_W > RATE_W + 1) ? QUOT_W : RATE_W + 1;
  localparam logic [POS_W-1:0] POS_END = POS_W'(GROUP_LEN - 1);

  // ---------------------------------------------------------------- state
  state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  logic [2:0] chan_cnt_q, chan_cnt_d;
  logic [1:0] chan_sel_q, chan_sel_d;
  logic [7:0] mask_q, mask_d;

  logic [1:0]       phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       prev_o_q, prev_o_d, prev_f_q, prev_f_d, prev_fi_q, prev_fi_d;
  logic [SUM_W-1:0] base_q, base_d, fsum_q, fsum_d, fisum_q, fisum_d;
  logic [COUNT_BITS-1:0] counts_q [6];
  logic [COUNT_BITS-1:0] counts_d [6];
  logic last_q, last_d, grp_end_q, grp_end_d;
  logic out_valid_q, out_valid_d;

  logic [7:0]       smp_q, smp_d, f_q, f_d, fi_q, fi_d;
  logic [ALU_W-1:0] diff_q, diff_d, num_q, num_d, den_q, den_d;
  logic             neg_q, neg_d, den_zero_q, den_zero_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  // ---------------------------------------------------------------- shared units
  alu_op_e          alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  alu_flags_t       alu_flags;
  logic             div_start, div_done;
  logic [QUOT_W-1:0] quot;

  rsgc_alu #(.W(ALU_W)) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .y_o     (alu_y),
    .flags_o (alu_flags)
  );

  rsgc_div #(.CNT_W(COUNT_BITS)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_mag_i (diff_q[COUNT_BITS-1:0]),
    .den_mag_i (alu_y[COUNT_BITS:0]),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // ---------------------------------------------------------------- helpers
  function automatic logic [7:0] flip_px(input logic [7:0] v, input logic [1:0] code,
                                         input logic inv);
    logic plus, minus, up;
    plus  = (code == MASK_PLUS)  ^ (inv && (code == MASK_PLUS || code == MASK_MINUS));
    minus = (code == MASK_MINUS) ^ (inv && (code == MASK_PLUS || code == MASK_MINUS));
    up    = v[0] ? minus : plus;
    if (!plus && !minus) begin
      flip_px = v;
    end else if (up) begin
      flip_px = (v == PIX_MAX) ? PIX_MAX : v + 8'd1;
    end else begin
      flip_px = (v == 8'd0) ? 8'd0 : v - 8'd1;
    end
  endfunction

  logic       in_acc, fin_go, out_acc;
  logic [2:0] cc_eff;
  logic [1:0] phase_eff, phase_nxt;
  logic       acc_sel, grp_end_now;
  logic [1:0] mask_code;
  logic [2:0] bump_idx;
  logic [SAT_W-1:0]  q_ext;
  logic [RATE_W-1:0] rate_val;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (chan_cnt_q < CHANNEL_COUNT_MIN) begin
      cc_eff = CHANNEL_COUNT_MIN;
    end else if (chan_cnt_q > CHANNEL_COUNT_MAX) begin
      cc_eff = CHANNEL_COUNT_MAX;
    end else begin
      cc_eff = chan_cnt_q;
    end
    phase_eff   = ({1'b0, phase_q} >= cc_eff) ? 2'd0 : phase_q;
    phase_nxt   = ({1'b0, phase_eff} + 3'd1 >= cc_eff) ? 2'd0 : phase_eff + 2'd1;
    acc_sel     = (phase_eff == chan_sel_q);
    grp_end_now = (pos_q == POS_END);
    mask_code   = mask_q[{pos_q, 1'b0} +: 2];

    // class slot: rose -> regular, fell -> singular, same -> unusable
    if (alu_flags.zero) begin
      bump_idx = CNT_UNUSABLE;
    end else if (alu_flags.neg) begin
      bump_idx = CNT_SINGULAR;
    end else begin
      bump_idx = CNT_REGULAR;
    end
    if (step_q == CLASS_LAST) begin
      bump_idx = bump_idx + CNT_INV_OFS;
    end

    q_ext = SAT_W'(quot);
    if (den_zero_q) begin
      rate_val = '0;
    end else if (neg_q) begin
      rate_val = (q_ext > SAT_W'(RATE_MIN)) ? RATE_MIN : RATE_W'(~q_ext + SAT_W'(1));
    end else begin
      rate_val = (q_ext > SAT_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(q_ext);
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_acc) begin
          if (acc_sel && (pos_q != '0)) begin
            state_d = ST_DIFF;
          end else if (acc_sel && grp_end_now) begin
            state_d = ST_CLASS;
          end else if (s_axis_tlast) begin
            state_d = ST_RATE;
          end
        end
      end
      ST_DIFF: begin
        if (step_q == DIFF_LAST) begin
          step_d = '0;
          if (grp_end_q) begin
            state_d = ST_CLASS;
          end else if (last_q) begin
            state_d = ST_RATE;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_CLASS: begin
        if (step_q == CLASS_LAST) begin
          step_d  = '0;
          state_d = last_q ? ST_RATE : ST_IDLE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_RATE: begin
        step_d = step_q + 3'd1;
        if ((step_q == RS_DEN) && alu_flags.zero) begin
          state_d = ST_FIN;
        end else if (step_q == RS_ABS_DEN) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    div_start = 1'b0;
    case (state_q)
      ST_DIFF: begin
        // even steps take the neighbor difference, odd steps accumulate |d|
        alu_op = step_q[0] ? ALU_ADDABS : ALU_SUB;
        alu_b  = diff_q;
        case (step_q[2:1])
          2'd0: begin
            alu_a = step_q[0] ? ALU_W'(base_q) : ALU_W'(smp_q);
            if (!step_q[0]) alu_b = ALU_W'(prev_o_q);
          end
          2'd1: begin
            alu_a = step_q[0] ? ALU_W'(fsum_q) : ALU_W'(f_q);
            if (!step_q[0]) alu_b = ALU_W'(prev_f_q);
          end
          default: begin
            alu_a = step_q[0] ? ALU_W'(fisum_q) : ALU_W'(fi_q);
            if (!step_q[0]) alu_b = ALU_W'(prev_fi_q);
          end
        endcase
      end
      ST_CLASS: begin
        alu_op = ALU_SUB;
        alu_a  = (step_q == CLASS_LAST) ? ALU_W'(fisum_q) : ALU_W'(fsum_q);
        alu_b  = ALU_W'(base_q);
      end
      ST_RATE: begin
        case (step_q)
          RS_NUM: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(counts_q[CNT_REGULAR]);
            alu_b  = ALU_W'(counts_q[CNT_SINGULAR]);
          end
          RS_PAIR: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(counts_q[CNT_REG_INV]);
            alu_b  = ALU_W'(counts_q[CNT_SING_INV]);
          end
          RS_DEN: begin
            alu_a = num_q;
            alu_b = diff_q;
          end
          RS_ABS_NUM: begin
            alu_op = ALU_ADDABS;
            alu_b  = num_q;
          end
          default: begin
            alu_op    = ALU_ADDABS;
            alu_b     = den_q;
            div_start = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    chan_cnt_d = chan_cnt_q;
    chan_sel_d = chan_sel_q;
    mask_d     = mask_q;
    phase_d    = phase_q;
    pos_d      = pos_q;
    prev_o_d   = prev_o_q;
    prev_f_d   = prev_f_q;
    prev_fi_d  = prev_fi_q;
    base_d     = base_q;
    fsum_d     = fsum_q;
    fisum_d    = fisum_q;
    counts_d   = counts_q;
    last_d     = last_q;
    grp_end_d  = grp_end_q;
    out_valid_d = out_valid_q;
    smp_d      = smp_q;
    f_d        = f_q;
    fi_d       = fi_q;
    diff_d     = diff_q;
    num_d      = num_q;
    den_d      = den_q;
    neg_d      = neg_q;
    den_zero_d = den_zero_q;
    out_data_d = out_data_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CHANNEL_COUNT:  chan_cnt_d = cfg_data_i[2:0];
        CFG_CHANNEL_SELECT: chan_sel_d = cfg_data_i[1:0];
        CFG_MASK_PATTERN:   mask_d     = cfg_data_i;
        default: ;
      endcase
    end

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          phase_d   = phase_nxt;
          last_d    = s_axis_tlast;
          grp_end_d = acc_sel && grp_end_now;
          if (acc_sel) begin
            smp_d = s_axis_tdata;
            f_d   = flip_px(s_axis_tdata, mask_code, 1'b0);
            fi_d  = flip_px(s_axis_tdata, mask_code, 1'b1);
            pos_d = grp_end_now ? '0 : pos_q + POS_W'(1);
            // first byte of a group only seeds the neighbor registers
            if (pos_q == '0) begin
              prev_o_d  = s_axis_tdata;
              prev_f_d  = flip_px(s_axis_tdata, mask_code, 1'b0);
              prev_fi_d = flip_px(s_axis_tdata, mask_code, 1'b1);
            end
          end
        end
      end
      ST_DIFF: begin
        if (!step_q[0]) begin
          diff_d = alu_y;
        end else begin
          case (step_q[2:1])
            2'd0:    base_d  = alu_y[SUM_W-1:0];
            2'd1:    fsum_d  = alu_y[SUM_W-1:0];
            default: fisum_d = alu_y[SUM_W-1:0];
          endcase
        end
        if (step_q == DIFF_LAST) begin
          prev_o_d  = smp_q;
          prev_f_d  = f_q;
          prev_fi_d = fi_q;
        end
      end
      ST_CLASS: begin
        if (counts_q[bump_idx] != '1) begin
          counts_d[bump_idx] = counts_q[bump_idx] + COUNT_BITS'(1);
        end
        if (step_q == CLASS_LAST) begin
          base_d  = '0;
          fsum_d  = '0;
          fisum_d = '0;
        end
      end
      ST_RATE: begin
        case (step_q)
          RS_NUM:     num_d = alu_y;
          RS_PAIR:    diff_d = alu_y;
          RS_DEN: begin
            den_d      = alu_y;
            den_zero_d = alu_flags.zero;
          end
          RS_ABS_NUM: diff_d = alu_y;
          default:    neg_d = num_q[ALU_W-1] ^ den_q[ALU_W-1];
        endcase
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          out_data_d  = {rate_val,
                         OUT_CNT_W'(counts_q[CNT_UNUS_INV]),
                         OUT_CNT_W'(counts_q[CNT_SING_INV]),
                         OUT_CNT_W'(counts_q[CNT_REG_INV]),
                         OUT_CNT_W'(counts_q[CNT_UNUSABLE]),
                         OUT_CNT_W'(counts_q[CNT_SINGULAR]),
                         OUT_CNT_W'(counts_q[CNT_REGULAR])};
          phase_d   = '0;
          pos_d     = '0;
          prev_o_d  = '0;
          prev_f_d  = '0;
          prev_fi_d = '0;
          base_d    = '0;
          fsum_d    = '0;
          fisum_d   = '0;
          for (int i = 0; i < 6; i++) begin
            counts_d[i] = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      chan_cnt_q  <= CHANNEL_COUNT_RST;
      chan_sel_q  <= CHANNEL_SELECT_RST;
      mask_q      <= MASK_PATTERN_RST;
      phase_q     <= '0;
      pos_q       <= '0;
      prev_o_q    <= '0;
      prev_f_q    <= '0;
      prev_fi_q   <= '0;
      base_q      <= '0;
      fsum_q      <= '0;
      fisum_q     <= '0;
      for (int i = 0; i < 6; i++) begin
        counts_q[i] <= '0;
      end
      last_q      <= 1'b0;
      grp_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      chan_cnt_q  <= chan_cnt_d;
      chan_sel_q  <= chan_sel_d;
      mask_q      <= mask_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      prev_o_q    <= prev_o_d;
      prev_f_q    <= prev_f_d;
      prev_fi_q   <= prev_fi_d;
      base_q      <= base_d;
      fsum_q      <= fsum_d;
      fisum_q     <= fisum_d;
      counts_q    <= counts_d;
      last_q      <= last_d;
      grp_end_q   <= grp_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    f_q        <= f_d;
    fi_q       <= fi_d;
    diff_q     <= diff_d;
    num_q      <= num_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    den_zero_q <= den_zero_d;
    out_data_q <= out_data_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### hdl/rsgc_alu.sv
// ----------------------------------------------------------------------------
// rsgc_alu
// Shared add / subtract / add-magnitude unit with sign and zero flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsgc_alu
  import rsgc_pkg::*;
#(
  parameter int unsigned W = 34
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] y_o,
  output alu_flags_t   flags_o
);

  logic negate;
  logic [W-1:0] b_eff;

  always_comb begin
    case (op_i)
      ALU_ADD:    negate = 1'b0;
      ALU_SUB:    negate = 1'b1;
      ALU_ADDABS: negate = b_i[W-1];
      default:    negate = 1'b0;
    endcase
    b_eff = negate ? (~b_i + W'(1)) : b_i;
    y_o   = a_i + b_eff;
    flags_o.neg  = y_o[W-1];
    flags_o.zero = (y_o == '0);
  end

endmodule

`default_nettype wire

### hdl/rsgc_div.sv
// ----------------------------------------------------------------------------
// rsgc_div
// Restoring divider, one quotient bit per cycle: (n*2^17 + d) / (2*d).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsgc_div
  import rsgc_pkg::*;
#(
  parameter int unsigned CNT_W = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [CNT_W-1:0]              num_mag_i,
  input  logic [CNT_W:0]                den_mag_i,
  output logic                          done_o,
  output logic [CNT_W+FRAC_BITS+1:0]    quot_o
);

  localparam int unsigned DVD_W = CNT_W + FRAC_BITS + 2;
  localparam int unsigned DVS_W = CNT_W + 2;
  localparam int unsigned CTR_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CTR_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dvd_q[DVD_W-1]};
    fits   = (trial >= {1'b0, dvs_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CTR_W'(DVD_W);
      dvd_d  = (DVD_W'(num_mag_i) << (FRAC_BITS + 1)) + DVD_W'(den_mag_i);
      rem_d  = '0;
      dvs_d  = {den_mag_i, 1'b0};
    end else if (busy_q) begin
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - CTR_W'(1);
      if (cnt_q == CTR_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // final step lands on the same edge that the sequencer sees done
  assign done_o = busy_q && (cnt_q == CTR_W'(1));
  assign quot_o = dvd_q;

endmodule

`default_nettype wire
